// ----- design/assert_macros.svh -----
// Assertion macros shared by the escaped frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/efr_pkg.sv -----
// Types and constants of the escaped frame receiver.
package efr_pkg;

    localparam int unsigned MAX_FRAME_DEF = 1024;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned TMO_W  = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned IDX_W  = 2;

    localparam logic [BYTE_W-1:0] MARK_START = 8'hD1;
    localparam logic [BYTE_W-1:0] MARK_END   = 8'hD2;
    localparam logic [BYTE_W-1:0] MARK_ESC   = 8'hD0;
    localparam logic [BYTE_W-1:0] ESC_MAXVAL = 8'd3;

    localparam logic [TMO_W-1:0] RX_TIMEOUT_RST = 8'd200;
    localparam logic [LEN_W-1:0] MAX_LEN_RST    = 11'd539;

    localparam logic [IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_RX_TIMEOUT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

    localparam int unsigned RES_FIFO_DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  frame_length;
        logic              overflow;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_dec_out;

endpackage

// ----- design/efr_decode.sv -----
// Per-item deframing logic, frame state and configuration registers.
`include "assert_macros.svh"

module efr_decode
    import efr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_acc,
    input  logic              i_mode,
    input  logic [BYTE_W-1:0] i_byte,
    output t_dec_out          o_dec
);

    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] FRAME_CAP =
        (MAX_FRAME > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_FRAME);

    logic              r_en;
    logic [TMO_W-1:0]  r_tmo;
    logic [LEN_W-1:0]  r_max_len;

    logic              r_in_frame, n_in_frame;
    logic [TMO_W-1:0]  r_tick_cnt, n_tick_cnt;
    logic              r_esc_pend, n_esc_pend;
    logic              r_exp_cmd, n_exp_cmd;
    logic [LEN_W-1:0]  r_raw_cnt, n_raw_cnt;
    logic [LEN_W-1:0]  r_dec_cnt, n_dec_cnt;
    logic              r_ovf, n_ovf;

    logic [LEN_W-1:0]  limit;
    logic [1:0]        cnt;
    t_res              r0, r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_tmo     <= RX_TIMEOUT_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_en      <= i_cfg_data[0];
                CFG_RX_TIMEOUT: r_tmo     <= i_cfg_data[TMO_W-1:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign limit = (r_max_len > FRAME_CAP) ? FRAME_CAP : r_max_len;

    always_comb begin
        n_in_frame = r_in_frame;
        n_tick_cnt = r_tick_cnt;
        n_esc_pend = r_esc_pend;
        n_exp_cmd  = r_exp_cmd;
        n_raw_cnt  = r_raw_cnt;
        n_dec_cnt  = r_dec_cnt;
        n_ovf      = r_ovf;
        cnt        = 2'd0;
        r0         = '0;
        r1         = '0;
        r0.overflow = r_ovf;
        r1.overflow = r_ovf;
        if (i_acc && r_en) begin
            if (i_mode) begin
                if (!r_in_frame) begin
                    n_tick_cnt = '0;
                end else if (r_tick_cnt > r_tmo) begin
                    cnt     = 2'd1;
                    r0.kind = KIND_ABORT;
                end else begin
                    n_tick_cnt = r_tick_cnt + TMO_W'(1);
                end
            end else if (i_byte == MARK_START) begin
                n_in_frame = 1'b1;
                n_esc_pend = 1'b0;
                n_exp_cmd  = 1'b1;
                n_raw_cnt  = '0;
                n_dec_cnt  = '0;
                n_ovf      = 1'b0;
            end else if (i_byte == MARK_END) begin
                if (r_esc_pend) begin
                    cnt             = 2'd2;
                    r0.kind         = KIND_DATA;
                    r0.data         = MARK_ESC;
                    r1.kind         = KIND_END;
                    r1.frame_length = r_dec_cnt + LEN_W'(1);
                end else begin
                    cnt             = 2'd1;
                    r0.kind         = KIND_END;
                    r0.frame_length = r_dec_cnt;
                end
            end else if (r_raw_cnt >= limit) begin
                n_ovf = 1'b1;
            end else begin
                n_raw_cnt = r_raw_cnt + LEN_W'(1);
                if (r_exp_cmd) begin
                    n_exp_cmd = 1'b0;
                    cnt       = 2'd1;
                    r0.kind   = KIND_CMD;
                    r0.data   = i_byte;
                end else if (r_esc_pend) begin
                    if (i_byte <= ESC_MAXVAL) begin
                        n_esc_pend = 1'b0;
                        n_dec_cnt  = r_dec_cnt + LEN_W'(1);
                        cnt        = 2'd1;
                        r0.data    = MARK_ESC + i_byte;
                    end else if (i_byte != MARK_ESC) begin
                        n_esc_pend = 1'b0;
                        n_dec_cnt  = r_dec_cnt + LEN_W'(2);
                        cnt        = 2'd2;
                        r0.data    = MARK_ESC;
                        r1.data    = i_byte;
                    end else begin
                        n_dec_cnt = r_dec_cnt + LEN_W'(1);
                        cnt       = 2'd1;
                        r0.data   = MARK_ESC;
                    end
                end else if (i_byte == MARK_ESC) begin
                    n_esc_pend = 1'b1;
                end else begin
                    n_dec_cnt = r_dec_cnt + LEN_W'(1);
                    cnt       = 2'd1;
                    r0.data   = i_byte;
                end
            end
            // end marker and timeout both close the frame
            if ((i_mode && r_in_frame && (r_tick_cnt > r_tmo)) ||
                (!i_mode && (i_byte == MARK_END))) begin
                n_in_frame = 1'b0;
                n_tick_cnt = '0;
                n_esc_pend = 1'b0;
                n_exp_cmd  = 1'b1;
                n_raw_cnt  = '0;
                n_dec_cnt  = '0;
                n_ovf      = 1'b0;
            end
        end
        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_tick_cnt <= '0;
            r_esc_pend <= 1'b0;
            r_exp_cmd  <= 1'b1;
            r_raw_cnt  <= '0;
            r_dec_cnt  <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_tick_cnt <= n_tick_cnt;
            r_esc_pend <= n_esc_pend;
            r_exp_cmd  <= n_exp_cmd;
            r_raw_cnt  <= n_raw_cnt;
            r_dec_cnt  <= n_dec_cnt;
            r_ovf      <= n_ovf;
        end
    end

    assign o_dec = '{cnt: cnt, r0: r0, r1: r1};

    `ASSERT_SYNC(a_dec_le_raw, i_clk, i_rst_n, ({1'b0, r_dec_cnt} + {{LEN_W{1'b0}}, r_esc_pend}) <= {1'b0, r_raw_cnt})
    `ASSERT_IMPL(a_esc_after_cmd, i_clk, i_rst_n, r_esc_pend, !r_exp_cmd)
    `ASSERT_IMPL(a_ticks_in_frame, i_clk, i_rst_n, r_tick_cnt != '0, r_in_frame)
    `ASSERT_NEXT(a_off_no_change, i_clk, i_rst_n, !r_en && !i_cfg_we, r_raw_cnt == $past(r_raw_cnt) && r_in_frame == $past(r_in_frame))

endmodule

// ----- design/efr_res_fifo.sv -----
// Result queue taking up to two results per cycle and giving one while i_ready is high.
`include "assert_macros.svh"

module efr_res_fifo
    import efr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dec_out i_dec,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_res     o_res
);

    t_res             r_mem [RES_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= CNT_W'(RES_FIFO_DEPTH - 2));
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_dec.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_dec.r0;
        end
        if (i_dec.cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_dec.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_dec.cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_cnt    <= r_cnt + CNT_W'(i_dec.cnt) - CNT_W'(pop);
        end
    end

    `ASSERT_SYNC(a_cnt_max, i_clk, i_rst_n, r_cnt <= CNT_W'(RES_FIFO_DEPTH))
    `ASSERT_IMPL(a_push_fits, i_clk, i_rst_n, i_dec.cnt != 2'd0, (r_cnt + CNT_W'(i_dec.cnt)) <= CNT_W'(RES_FIFO_DEPTH))
    `ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && (i_dec.cnt == 2'd0), r_cnt == $past(r_cnt) - CNT_W'(1))

endmodule

// ----- design/escaped_frame_receiver.sv -----
// Top level of the escaped frame receiver: byte-stuffed frame deframer.
//
//  channel  dir  payload                                        handshake
//  s_axis   in   tdata byte_value, tuser mode                   tvalid/tready
//  m_axis   out  tdata data/frame_length/overflow, tuser kind   tvalid/tready, tlast
//  cfg      in   i_cfg_index, i_cfg_data                        i_cfg_we
//
// One input item per cycle while s_axis_tready is high, decoded in the accept
// cycle into 0..2 results; results pass a 4-entry queue and the output port
// gives one per cycle while m_axis_tready is high, so two-result items slow the
// input. s_axis_tready drops when the queue has room for fewer than two results.
// Reset is synchronous (i_rst_n low); it clears frame state and the queue.
module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] byte_value
    input  logic              s_axis_tuser,   // [0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [7:0] data, [18:8] frame_length,
                                              // [19] overflow, [23:20] zero
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    t_dec_out dec;
    t_res     res;
    logic     acc;

    assign acc = s_axis_tvalid && s_axis_tready;

    efr_decode #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_mode      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .o_dec       (dec)
    );

    efr_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {4'b0, res.overflow, res.frame_length, res.data};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ----- dv/testbench.sv -----
// Testbench for the escaped frame receiver: directed and random link streams checked by a deframer model.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [LEN_W-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] byte_value
    logic              s_axis_tuser = 1'b0; // [0] mode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // [7:0] data, [18:8] frame_length, [19] overflow
    logic [1:0]        m_axis_tuser;        // [1:0] kind
    logic              m_axis_tlast;

    escaped_frame_receiver i_dut (.*);

    // deframer model state
    bit               cfg_enable;
    logic [7:0]       cfg_rx_timeout;
    logic [LEN_W-1:0] cfg_max_length;
    bit               in_frame;
    bit               esc_pending;
    bit               want_cmd;
    bit               overflowed;
    logic [7:0]       tick_count;
    logic [LEN_W-1:0] raw_count;
    logic [LEN_W-1:0] decoded_count;

    t_res decoded_queue[$];
    t_res step_out[$];

    int  errors = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  fast_flow = 1'b0;
    bit  valid_held = 1'b0;

    initial forever #4 i_clk = ~i_clk;

    function automatic void clear_frame();
        in_frame = 1'b0;
        tick_count = '0;
        esc_pending = 1'b0;
        want_cmd = 1'b1;
        raw_count = '0;
        decoded_count = '0;
        overflowed = 1'b0;
    endfunction

    function automatic void reset_model();
        cfg_enable = 1'b0;
        cfg_rx_timeout = RX_TIMEOUT_RST;
        cfg_max_length = MAX_LEN_RST;
        clear_frame();
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [LEN_W-1:0] len);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.frame_length = len;
        r.overflow = overflowed;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void deframe_item(logic mode, logic [7:0] b);
        logic [LEN_W-1:0] limit;
        limit = (cfg_max_length > LEN_W'(MAX_FRAME_DEF)) ? LEN_W'(MAX_FRAME_DEF) : cfg_max_length;
        step_out.delete();
        if (!cfg_enable) return;
        if (mode == MODE_TICK) begin
            if (!in_frame) begin
                tick_count = '0;
            end else if (tick_count > cfg_rx_timeout) begin
                emit(KIND_ABORT, '0, '0);
                clear_frame();
            end else begin
                tick_count = tick_count + 8'd1;
            end
        end else if (b == MARK_START) begin
            in_frame = 1'b1;
            esc_pending = 1'b0;
            want_cmd = 1'b1;
            raw_count = '0;
            decoded_count = '0;
            overflowed = 1'b0;
        end else if (b == MARK_END) begin
            if (esc_pending) begin
                decoded_count++;
                emit(KIND_DATA, MARK_ESC, '0);
            end
            emit(KIND_END, '0, decoded_count);
            clear_frame();
        end else if (raw_count >= limit) begin
            overflowed = 1'b1;
        end else begin
            raw_count++;
            if (want_cmd) begin
                want_cmd = 1'b0;
                emit(KIND_CMD, b, '0);
            end else if (esc_pending) begin
                decoded_count++;
                if (b <= ESC_MAXVAL) begin
                    esc_pending = 1'b0;
                    emit(KIND_DATA, MARK_ESC + b, '0);
                end else begin
                    emit(KIND_DATA, MARK_ESC, '0);
                    // a second escape byte opens a new escape
                    if (b != MARK_ESC) begin
                        esc_pending = 1'b0;
                        decoded_count++;
                        emit(KIND_DATA, b, '0);
                    end
                end
            end else if (b == MARK_ESC) begin
                esc_pending = 1'b1;
            end else begin
                decoded_count++;
                emit(KIND_DATA, b, '0);
            end
        end
        if (step_out.size() > 0) step_out[$].last = 1'b1;
        foreach (step_out[i]) decoded_queue.push_back(step_out[i]);
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_item(logic mode, logic [7:0] b);
        int gap;
        gap = fast_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            if (valid_held) begin
                s_axis_tvalid <= 1'b0;
                valid_held = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= b;
        valid_held = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        deframe_item(mode, b);
        items_sent++;
    endtask

    task automatic send_bytes(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_item(MODE_BYTE, bytes[i]);
    endtask

    task automatic stop_sending();
        if (valid_held) begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
        end
        @(posedge i_clk);
    endtask

    task automatic drain_outputs();
        stop_sending();
        while (decoded_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:     cfg_enable = val[0];
            CFG_RX_TIMEOUT: cfg_rx_timeout = val[7:0];
            CFG_MAX_LENGTH: cfg_max_length = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
            else send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_frame();
        int pick;
        logic [7:0] cmd;
        send_item(MODE_BYTE, MARK_START);
        if ($urandom_range(0, 9) != 0) begin
            cmd = 8'($urandom_range(0, 255));
            if (cmd == MARK_START || cmd == MARK_END) cmd = MARK_ESC;
            send_item(MODE_BYTE, cmd);
        end
        repeat ($urandom_range(0, 12)) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) send_item(MODE_BYTE, MARK_ESC);
            else if (pick < 40) send_item(MODE_BYTE, 8'($urandom_range(0, 3)));
            else if (pick < 50) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
            else if (pick < 53) send_item(MODE_BYTE, MARK_START);
            else send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0) send_item(MODE_BYTE, MARK_END);
    endtask

    task automatic run_phase(logic [7:0] tmo, logic [LEN_W-1:0] max_len, int n_items);
        int target;
        wait_quiet();
        write_reg(CFG_RX_TIMEOUT, LEN_W'(tmo));
        write_reg(CFG_MAX_LENGTH, max_len);
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) fast_flow = !fast_flow;
            if ($urandom_range(0, 6) == 0) send_noise();
            else send_frame();
            if ($urandom_range(0, 9) == 0) drain_outputs();
        end
    endtask

    task automatic test_disabled();
        logic [7:0] seq[$];
        seq = '{MARK_START, 8'h12, 8'h34, MARK_ESC, 8'h01, MARK_END};
        send_bytes(seq);
        send_item(MODE_TICK, 8'h00);
        wait_quiet();
        write_reg(CFG_ENABLE, 11'd1);
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        // end with no command, then a command byte outside any frame
        seq = '{MARK_END, 8'h41};
        send_bytes(seq);
        seq = '{MARK_START, 8'h00};
        send_bytes(seq);
        send_item(MODE_TICK, 8'hFF);
        // escapes: in range, out of range, double escape, trailing escape
        seq = '{8'hFF, MARK_ESC, 8'h00, MARK_ESC, 8'h03, MARK_ESC, 8'h04,
                MARK_ESC, MARK_ESC, 8'h01, MARK_ESC, MARK_END};
        send_bytes(seq);
        // restart discards a pending escape
        seq = '{MARK_START, 8'h7F, MARK_ESC, MARK_START, 8'h80, MARK_END};
        send_bytes(seq);
        send_item(MODE_TICK, 8'h00);
    endtask

    task automatic test_timeout();
        logic [7:0] seq[$];
        wait_quiet();
        write_reg(CFG_RX_TIMEOUT, 11'd0);
        seq = '{MARK_START, 8'h55};
        send_bytes(seq);
        repeat (3) send_item(MODE_TICK, 8'hA5);
        send_item(MODE_BYTE, MARK_END);
        // count wraps and never aborts
        wait_quiet();
        write_reg(CFG_RX_TIMEOUT, 11'd255);
        seq = '{MARK_START, 8'h5A};
        send_bytes(seq);
        repeat (260) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
        seq = '{8'h33, MARK_END};
        send_bytes(seq);
    endtask

    task automatic test_overflow();
        logic [7:0] seq[$];
        wait_quiet();
        write_reg(CFG_MAX_LENGTH, 11'd2);
        seq = '{MARK_START, 8'h66, 8'h10, 8'h20, MARK_ESC, MARK_END,
                MARK_START, 8'h77, MARK_END};
        send_bytes(seq);
    endtask

    task automatic test_disable_midstream();
        wait_quiet();
        write_reg(CFG_ENABLE, 11'd0);
        repeat (4) send_noise();
        wait_quiet();
        write_reg(CFG_ENABLE, 11'd1);
    endtask

    task automatic test_random_traffic();
        run_phase(8'd3, 11'd8, 55);
        run_phase(8'd0, 11'd2, 45);
        test_disable_midstream();
        run_phase(8'd255, 11'd1024, 55);
        run_phase(8'($urandom_range(1, 6)), 11'($urandom_range(2, 24)), 55);
        run_phase(8'd200, 11'd539, 55);
    endtask

    // result checker: samples at the falling edge what the next rising edge accepts
    always @(negedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (decoded_queue.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata, 24'd0);
            end else begin
                want = decoded_queue.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", 24'(m_axis_tuser), 24'(want.kind));
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("data", 24'(m_axis_tdata[7:0]), 24'(want.data));
                if (m_axis_tdata[18:8] !== want.frame_length)
                    report_mismatch("frame_length", 24'(m_axis_tdata[18:8]),
                                    24'(want.frame_length));
                if (m_axis_tdata[19] !== want.overflow)
                    report_mismatch("overflow", 24'(m_axis_tdata[19]), 24'(want.overflow));
                if (m_axis_tdata[23:20] !== 4'd0)
                    report_mismatch("tdata pad", 24'(m_axis_tdata[23:20]), 24'd0);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 24'(m_axis_tlast), 24'(want.last));
            end
        end
    end

    // output backpressure
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = fast_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[escaped_frame_receiver] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled();
        test_directed();
        test_timeout();
        test_overflow();
        test_random_traffic();
        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[escaped_frame_receiver] OK");
        end else begin
            $display("[escaped_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule
